FILE: src/tmcd_pkg.sv
// package: result word type, event codes and opcode constants of the tile map command decoder
package tmcd_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [2:0] EV_MAP_WRITE   = 3'd0;
	localparam logic [2:0] EV_TILE_COPY   = 3'd1;
	localparam logic [2:0] EV_BORDER_SET  = 3'd2;
	localparam logic [2:0] EV_FRAME_END   = 3'd3;
	localparam logic [2:0] EV_BANK_ADV    = 3'd4;
	localparam logic [2:0] EV_DONE        = 3'd5;

	localparam logic [7:0] OP_SKIP_MAX    = 8'h7F;
	localparam logic [7:0] OP_COPY_MAX    = 8'hBF;
	localparam logic [7:0] OP_WRITE_MAX   = 8'hEF;
	localparam logic [7:0] OP_DONE        = 8'hF0;
	localparam logic [7:0] OP_BANK_ADV    = 8'hF1;
	localparam logic [7:0] OP_EMPTY       = 8'hF4;
	localparam logic [7:0] OP_EMPTY_INV   = 8'hF5;
	localparam logic [7:0] OP_BORDER_W    = 8'hF6;
	localparam logic [7:0] OP_BORDER_B    = 8'hF7;
	localparam logic [7:0] OP_FRAME_MIN   = 8'hF8;

	localparam logic [15:0] TILE_EMPTY     = 16'h0000;
	localparam logic [15:0] TILE_EMPTY_INV = 16'h0200;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_TWO   = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	localparam logic [1:0] CFG_TWO_BPP   = 2'd0;
	localparam logic [1:0] CFG_BANK_BASE = 2'd1;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] map_index;
		logic [15:0] tile_word;
		logic [7:0]  src_bank;
		logic [15:0] src_offset;
		logic [8:0]  dest_tile;
		logic        border_black;
		logic [2:0]  frame_ticks;
		logic        last;
	} result_t;

endpackage

FILE: src/tile_map_command_decoder.sv
// top level: tile map command decoder, byte stream to map write and control events
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  cmd_byte
//   out      from block out_valid/out_stall  event_res .. last
//   cfg      to block   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a byte is held in the input register, then is decoded into up to two words
// pushed into a two-entry result queue; one byte per cycle while results drain
// a tile copy byte makes two words and holds the input register until both fit
// arst_n clears the decode state, registers and queue; no clearing pass
// out_stall backs up the queue and then in_stall; cfg_ready is always high
module tile_map_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cmd_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [15:0] map_index,
	output logic [15:0] tile_word,
	output logic [7:0]  src_bank,
	output logic [15:0] src_offset,
	output logic [8:0]  dest_tile,
	output logic        border_black,
	output logic [2:0]  frame_ticks,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic        two_bpp_q;
	logic [7:0]  bank_base_q;
	logic [15:0] position_q;
	logic [1:0]  pending_q;
	logic [7:0]  opcode_q;
	logic [7:0]  second_q;
	logic [7:0]  third_q;
	logic        finished_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	tmcd_pkg::result_t entry_q [tmcd_pkg::QueueDepth];
	logic [1:0]  count_q;

	logic [15:0] position_d;
	logic [1:0]  pending_d;
	logic [7:0]  opcode_d;
	logic [7:0]  second_d;
	logic [7:0]  third_d;
	logic        finished_d;
	logic [1:0]  nres;
	tmcd_pkg::result_t res0;
	tmcd_pkg::result_t res1;

	logic        pop;
	logic [1:0]  avail;
	logic        adv;
	logic        accept;
	tmcd_pkg::result_t next0;
	tmcd_pkg::result_t next1;
	logic [1:0]  count_d;

	logic [15:0] copy_word;
	logic [5:0]  copy_bank;
	logic [15:0] copy_offset;

	assign cfg_ready = 1'b1;

	always_comb begin
		copy_word = {opcode_q[5:4], 4'b0, opcode_q[3:0], second_q[7:2]};
		if (two_bpp_q) begin
			copy_bank   = {second_q[1:0], third_q[7:4]};
			copy_offset = {third_q[3:0], byte_s1, 4'b0};
		end else begin
			copy_bank   = {1'b0, second_q[1:0], third_q[7:5]};
			copy_offset = {third_q[4:0], byte_s1, 3'b0};
		end
	end

	always_comb begin
		position_d = position_q;
		pending_d  = pending_q;
		opcode_d   = opcode_q;
		second_d   = second_q;
		third_d    = third_q;
		finished_d = finished_q;
		nres       = 2'd0;
		res0       = '0;
		res1       = '0;
		res0.last  = 1'b1;
		res1.last  = 1'b1;
		if (finished_q) begin
			nres = 2'd0;
		end else if (pending_q != tmcd_pkg::PEND_NONE) begin
			if (opcode_q <= tmcd_pkg::OP_COPY_MAX) begin
				unique case (pending_q)
					tmcd_pkg::PEND_THREE: begin
						second_d  = byte_s1;
						pending_d = tmcd_pkg::PEND_TWO;
					end
					tmcd_pkg::PEND_TWO: begin
						third_d   = byte_s1;
						pending_d = tmcd_pkg::PEND_ONE;
					end
					default: begin
						pending_d       = tmcd_pkg::PEND_NONE;
						nres            = 2'd2;
						res0.event_res  = tmcd_pkg::EV_TILE_COPY;
						res0.src_bank   = bank_base_q + {2'b0, copy_bank};
						res0.src_offset = copy_offset;
						res0.dest_tile  = copy_word[8:0];
						res0.last       = 1'b0;
						res1.event_res  = tmcd_pkg::EV_MAP_WRITE;
						res1.map_index  = position_q;
						res1.tile_word  = copy_word;
						position_d      = position_q + 16'd1;
					end
				endcase
			end else begin
				pending_d      = tmcd_pkg::PEND_NONE;
				nres           = 2'd1;
				res0.event_res = tmcd_pkg::EV_MAP_WRITE;
				res0.map_index = position_q;
				res0.tile_word = {opcode_q[3:2], 4'b0, opcode_q[1:0], byte_s1};
				position_d     = position_q + 16'd1;
			end
		end else begin
			priority if (byte_s1 <= tmcd_pkg::OP_SKIP_MAX) begin
				position_d = position_q + {8'd0, byte_s1};
			end else if (byte_s1 <= tmcd_pkg::OP_COPY_MAX) begin
				opcode_d  = byte_s1;
				pending_d = tmcd_pkg::PEND_THREE;
			end else if (byte_s1 <= tmcd_pkg::OP_WRITE_MAX) begin
				opcode_d  = byte_s1;
				pending_d = tmcd_pkg::PEND_ONE;
			end else if (byte_s1 == tmcd_pkg::OP_EMPTY || byte_s1 == tmcd_pkg::OP_EMPTY_INV) begin
				nres           = 2'd1;
				res0.event_res = tmcd_pkg::EV_MAP_WRITE;
				res0.map_index = position_q;
				res0.tile_word = (byte_s1 == tmcd_pkg::OP_EMPTY_INV) ?
					tmcd_pkg::TILE_EMPTY_INV : tmcd_pkg::TILE_EMPTY;
				position_d     = position_q + 16'd1;
			end else if (byte_s1 == tmcd_pkg::OP_BANK_ADV) begin
				nres           = 2'd1;
				res0.event_res = tmcd_pkg::EV_BANK_ADV;
			end else if (byte_s1 == tmcd_pkg::OP_BORDER_W || byte_s1 == tmcd_pkg::OP_BORDER_B) begin
				nres              = 2'd1;
				res0.event_res    = tmcd_pkg::EV_BORDER_SET;
				res0.border_black = (byte_s1 == tmcd_pkg::OP_BORDER_B);
			end else if (byte_s1 >= tmcd_pkg::OP_FRAME_MIN) begin
				nres             = 2'd1;
				res0.event_res   = tmcd_pkg::EV_FRAME_END;
				res0.frame_ticks = byte_s1[2:0];
				position_d       = '0;
			end else if (byte_s1 == tmcd_pkg::OP_DONE) begin
				nres           = 2'd1;
				res0.event_res = tmcd_pkg::EV_DONE;
				finished_d     = 1'b1;
			end else begin
				nres = 2'd0;
			end
		end
	end

	// queue bookkeeping
	assign pop      = out_valid && !out_stall;
	assign avail    = count_q - {1'b0, pop};
	assign adv      = valid_s1 && ({1'b0, avail} + {1'b0, nres} <= 3'd2);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		next0   = pop ? entry_q[1] : entry_q[0];
		next1   = entry_q[1];
		count_d = avail;
		if (adv) begin
			count_d = avail + nres;
			if (avail == 2'd0) begin
				next0 = res0;
				next1 = res1;
			end else if (avail == 2'd1) begin
				next1 = res0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_bpp_q   <= 1'b0;
			bank_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tmcd_pkg::CFG_TWO_BPP:   two_bpp_q   <= cfg_data[0];
				tmcd_pkg::CFG_BANK_BASE: bank_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			pending_q  <= tmcd_pkg::PEND_NONE;
			opcode_q   <= '0;
			second_q   <= '0;
			third_q    <= '0;
			finished_q <= 1'b0;
			valid_s1   <= 1'b0;
			count_q    <= '0;
		end else begin
			if (adv) begin
				position_q <= position_d;
				pending_q  <= pending_d;
				opcode_q   <= opcode_d;
				second_q   <= second_d;
				third_q    <= third_d;
				finished_q <= finished_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= cmd_byte;
		end
		entry_q[0] <= next0;
		entry_q[1] <= next1;
	end

	assign out_valid    = (count_q != 2'd0);
	assign event_res    = entry_q[0].event_res;
	assign map_index    = entry_q[0].map_index;
	assign tile_word    = entry_q[0].tile_word;
	assign src_bank     = entry_q[0].src_bank;
	assign src_offset   = entry_q[0].src_offset;
	assign dest_tile    = entry_q[0].dest_tile;
	assign border_black = entry_q[0].border_black;
	assign frame_ticks  = entry_q[0].frame_ticks;
	assign last         = entry_q[0].last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("result queue overfilled");

	a_copy_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == tmcd_pkg::EV_TILE_COPY) |-> (count_q == 2'd2 && !last))
		else $error("tile copy word without its map write behind it");

	a_pending_op: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != tmcd_pkg::PEND_NONE) |-> (opcode_q > tmcd_pkg::OP_SKIP_MAX))
		else $error("operands pending on a skip opcode");

	a_finished_hold: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> (finished_q && $stable(position_q)))
		else $error("state moved after done");

endmodule
